>>> sv/assert_macros.svh
// Assertion shorthands for the RTL; each expects clk in scope, and ASSERT_CLK also rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/igrbf_pkg.sv
`default_nettype none

package igrbf_pkg;

    // Position item, signed Q8.8 on each axis
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } pos_t;

    // Result item: value Q0.16, gradients Q16.16
    typedef struct packed {
        logic [15:0]        value;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
    } res_t;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_WIDTH_X  = 2'd2,
        CFG_WIDTH_Y  = 2'd3
    } cfg_idx_t;

    localparam int EXP_DEPTH = 256;
    localparam int ARG_LIMIT = 16;
    localparam int TAYLOR_TERMS = 24;

    typedef logic [32:0] exp_rom_t [0:EXP_DEPTH];

    // Samples of exp(-x) on [0, ARG_LIMIT], Q1.32; each sample is the previous
    // one times a Taylor-series step factor.
    function automatic exp_rom_t build_exp_rom();
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] prod;
        exp_rom_t    rom;
        x    = (64'(ARG_LIMIT) << 32) / 64'(EXP_DEPTH);
        sum  = 64'h1_0000_0000;
        term = 64'h1_0000_0000;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * x) >> 32) / 64'(n);
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        rom[0] = 33'h1_0000_0000;
        for (int i = 1; i <= EXP_DEPTH; i++) begin
            prod   = 64'(rom[i - 1]) * sum;
            rom[i] = 33'(prod >> 32);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

>>> sv/inverted_gaussian_rbf_with_gradient_core.sv
// Inverted 2-D Gaussian with gradient, one result item per position item.
// Channels: pos_valid/pos_stall/pos_data take a position item; res_valid/
// res_stall/res_data deliver value = 1 - exp(-a) and the two gradients.
// An item moves on an edge where valid is high and stall is low.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write center_x,
// center_y, width_x, width_y; cfg_ready is always high. Write only when idle.
// Pipeline: 58 register stages. Throughput: one item per cycle while
// res_stall is low. Most of the length comes from the two unrolled
// restoring dividers (21 quotient bits for the exponent terms, 28 for the
// gradients).
// A stalled receiver holds the last stage; stages behind it keep filling
// their empty slots and pos_stall rises only when every stage is occupied.
// Reset clears all stage valid bits and loads the registers with centre 0
// and width 1.0; items in flight are dropped.
`default_nettype none
`include "assert_macros.svh"

module inverted_gaussian_rbf_with_gradient_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pos_valid,
    output logic                   pos_stall,
    input  wire igrbf_pkg::pos_t   pos_data,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output igrbf_pkg::res_t        res_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);

    localparam int TQ     = 21;
    localparam int GQ     = 28;
    localparam int ST_IN  = 0;
    localparam int ST_D   = 1;
    localparam int ST_SQ  = 2;
    localparam int TD0    = 3;
    localparam int ST_A   = TD0 + TQ;
    localparam int ST_ROM = ST_A + 1;
    localparam int ST_MUL = ST_A + 2;
    localparam int ST_E   = ST_A + 3;
    localparam int ST_GM  = ST_A + 4;
    localparam int GD0    = ST_A + 5;
    localparam int ST_OUT = GD0 + GQ;
    localparam int NST    = ST_OUT + 1;

    localparam logic [20:0] ARG_SAT = 21'h10_0000;

    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] mag_x;
        logic [15:0] mag_y;
        logic        neg_x;
        logic        neg_y;
        logic        sat_x;
        logic        sat_y;
        logic        zero_x;
        logic        zero_y;
        logic [14:0] s_x;
        logic [14:0] s_y;
        logic [29:0] s2_x;
        logic [29:0] s2_y;
        logic [48:0] num_x;
        logic [48:0] num_y;
        logic [38:0] rem_x;
        logic [38:0] rem_y;
        logic [27:0] q_x;
        logic [27:0] q_y;
        logic [20:0] arg;
        logic [32:0] t0;
        logic [32:0] t1;
        logic [15:0] frac;
        logic [48:0] prod;
        logic [32:0] e;
        logic [15:0] value;
        logic [31:0] grad_x;
        logic [31:0] grad_y;
    } stage_t;

    logic signed [15:0] center_x_reg;
    logic signed [15:0] center_y_reg;
    logic [14:0]        width_x_reg;
    logic [14:0]        width_y_reg;

    stage_t           pipe_reg  [0:NST-1];
    stage_t           pipe_next [0:NST-1];
    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   vld_next;
    logic [NST:0]     adv;

    // One restoring-division step: shift in a numerator bit, subtract if it fits
    function automatic logic [39:0] div_bit(logic [38:0] rem, logic nbit, logic [38:0] dv);
        logic [38:0] sh;
        sh = {rem[37:0], nbit};
        if (sh >= dv)
            return {sh - dv, 1'b1};
        return {sh, 1'b0};
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            width_x_reg  <= 15'd256;
            width_y_reg  <= 15'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (igrbf_pkg::cfg_idx_t'(cfg_index))
                igrbf_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                igrbf_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                igrbf_pkg::CFG_WIDTH_X:  width_x_reg  <= cfg_data[14:0];
                igrbf_pkg::CFG_WIDTH_Y:  width_y_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or the stage after it moves on
    assign adv[NST] = !res_stall;
    assign pos_stall = !adv[0];
    assign res_valid = vld_reg[NST-1];
    assign res_data.value  = pipe_reg[NST-1].value;
    assign res_data.grad_x = pipe_reg[NST-1].grad_x;
    assign res_data.grad_y = pipe_reg[NST-1].grad_y;

    for (genvar k = 0; k < NST; k++)
    begin : g_st
        assign adv[k] = !vld_reg[k] || adv[k+1];

        if (k == ST_IN)
        begin : g_in
            always_comb
            begin
                pipe_next[k]    = '0;
                pipe_next[k].px = pos_data.pos_x;
                pipe_next[k].py = pos_data.pos_y;
                vld_next[k]     = pos_valid;
            end
        end
        else if (k == ST_D)
        begin : g_diff
            always_comb
            begin
                logic signed [16:0] dx;
                logic signed [16:0] dy;
                logic [16:0]        mx;
                logic [16:0]        my;
                stage_t             nx;
                nx = pipe_reg[k-1];
                dx = $signed({nx.px[15], nx.px}) - $signed({center_x_reg[15], center_x_reg});
                dy = $signed({nx.py[15], nx.py}) - $signed({center_y_reg[15], center_y_reg});
                mx = dx[16] ? 17'(-dx) : 17'(dx);
                my = dy[16] ? 17'(-dy) : 17'(dy);
                nx.neg_x = dx[16];
                nx.neg_y = dy[16];
                nx.mag_x = mx[15:0];
                nx.mag_y = my[15:0];
                nx.s_x   = (width_x_reg == '0) ? 15'd1 : width_x_reg;
                nx.s_y   = (width_y_reg == '0) ? 15'd1 : width_y_reg;
                // |d| >= 8s saturates the term outright
                nx.sat_x = {2'b0, nx.mag_x} >= {nx.s_x, 3'b000};
                nx.sat_y = {2'b0, nx.mag_y} >= {nx.s_y, 3'b000};
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end
        else if (k == ST_SQ)
        begin : g_sq
            always_comb
            begin
                logic [31:0] m2x;
                logic [31:0] m2y;
                stage_t      nx;
                nx = pipe_reg[k-1];
                m2x = {16'b0, nx.mag_x} * {16'b0, nx.mag_x};
                m2y = {16'b0, nx.mag_y} * {16'b0, nx.mag_y};
                nx.s2_x  = {15'b0, nx.s_x} * {15'b0, nx.s_x};
                nx.s2_y  = {15'b0, nx.s_y} * {15'b0, nx.s_y};
                nx.num_x = {2'b0, m2x, 15'b0};
                nx.num_y = {2'b0, m2y, 15'b0};
                nx.rem_x = {13'b0, m2x[31:6]};
                nx.rem_y = {13'b0, m2y[31:6]};
                nx.q_x   = '0;
                nx.q_y   = '0;
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end
        else if (k < ST_A)
        begin : g_tdiv
            localparam int B = TQ - 1 - (k - TD0);
            always_comb
            begin
                logic [39:0] rx;
                logic [39:0] ry;
                stage_t      nx;
                nx = pipe_reg[k-1];
                rx = div_bit(nx.rem_x, nx.num_x[B], {9'b0, nx.s2_x});
                ry = div_bit(nx.rem_y, nx.num_y[B], {9'b0, nx.s2_y});
                nx.rem_x  = rx[39:1];
                nx.rem_y  = ry[39:1];
                nx.q_x[B] = rx[0];
                nx.q_y[B] = ry[0];
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end
        else if (k == ST_A)
        begin : g_arg
            always_comb
            begin
                logic [20:0] tx;
                logic [20:0] ty;
                logic [21:0] sum;
                stage_t      nx;
                nx = pipe_reg[k-1];
                tx  = nx.sat_x ? ARG_SAT : nx.q_x[20:0];
                ty  = nx.sat_y ? ARG_SAT : nx.q_y[20:0];
                sum = {1'b0, tx} + {1'b0, ty};
                nx.arg    = (sum >= {1'b0, ARG_SAT}) ? ARG_SAT : sum[20:0];
                nx.zero_x = nx.sat_x || nx.q_x[20];
                nx.zero_y = nx.sat_y || nx.q_y[20];
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end
        else if (k == ST_ROM)
        begin : g_rom
            always_comb
            begin
                logic [8:0] idx;
                stage_t     nx;
                nx = pipe_reg[k-1];
                idx = {1'b0, nx.arg[19:12]};
                if (nx.arg[20])
                begin
                    nx.t0 = '0;
                    nx.t1 = '0;
                end
                else
                begin
                    nx.t0 = igrbf_pkg::EXP_ROM[idx];
                    nx.t1 = igrbf_pkg::EXP_ROM[idx + 9'd1];
                end
                nx.frac = {nx.arg[11:0], 4'b0000};
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end
        else if (k == ST_MUL)
        begin : g_mul
            always_comb
            begin
                stage_t nx;
                nx = pipe_reg[k-1];
                nx.prod = {16'b0, nx.t0 - nx.t1} * {33'b0, nx.frac};
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end
        else if (k == ST_E)
        begin : g_e
            always_comb
            begin
                stage_t nx;
                nx = pipe_reg[k-1];
                nx.e = nx.t0 - nx.prod[48:16];
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end
        else if (k == ST_GM)
        begin : g_gm
            always_comb
            begin
                logic [33:0] v;
                stage_t      nx;
                nx = pipe_reg[k-1];
                // round 1 - e to Q0.16, clamp when e is tiny
                v = 34'h1_0000_0000 - {1'b0, nx.e} + 34'h8000;
                nx.value = (v[33:32] != 2'b00) ? 16'hFFFF : v[31:16];
                nx.num_x = {33'b0, nx.mag_x} * {16'b0, nx.e};
                nx.num_y = {33'b0, nx.mag_y} * {16'b0, nx.e};
                nx.rem_x = {18'b0, nx.num_x[48:28]};
                nx.rem_y = {18'b0, nx.num_y[48:28]};
                nx.q_x   = '0;
                nx.q_y   = '0;
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end
        else if (k < ST_OUT)
        begin : g_gdiv
            localparam int B = GQ - 1 - (k - GD0);
            always_comb
            begin
                logic [39:0] rx;
                logic [39:0] ry;
                stage_t      nx;
                nx = pipe_reg[k-1];
                rx = div_bit(nx.rem_x, nx.num_x[B], {1'b0, nx.s2_x, 8'b0});
                ry = div_bit(nx.rem_y, nx.num_y[B], {1'b0, nx.s2_y, 8'b0});
                nx.rem_x  = rx[39:1];
                nx.rem_y  = ry[39:1];
                nx.q_x[B] = rx[0];
                nx.q_y[B] = ry[0];
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end
        else
        begin : g_out
            always_comb
            begin
                logic [31:0] gx;
                logic [31:0] gy;
                stage_t      nx;
                nx = pipe_reg[k-1];
                gx = {4'b0, nx.q_x};
                gy = {4'b0, nx.q_y};
                // drop the gradient when the axis term or e is saturated
                if (nx.e == '0 || nx.zero_x)
                    nx.grad_x = '0;
                else
                    nx.grad_x = nx.neg_x ? 32'(-gx) : gx;
                if (nx.e == '0 || nx.zero_y)
                    nx.grad_y = '0;
                else
                    nx.grad_y = nx.neg_y ? 32'(-gy) : gy;
                pipe_next[k] = nx;
                vld_next[k]  = vld_reg[k-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv[k])
                vld_reg[k] <= vld_next[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
                pipe_reg[k] <= pipe_next[k];
        end
    end

    `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !res_valid, "result valid after reset")
    `ASSERT_CLK(a_e_zero_value, (vld_reg[ST_OUT] && pipe_reg[ST_OUT].e == '0) |-> (res_data.value == 16'hFFFF), "e zero but value not saturated")
    `ASSERT_CLK(a_sat_grad, (vld_reg[ST_OUT] && pipe_reg[ST_OUT].sat_x) |-> (res_data.grad_x == '0), "saturated axis gives nonzero gradient")
    `ASSERT_CLK(a_hold_mid, (vld_reg[ST_E] && !adv[ST_E]) |=> (vld_reg[ST_E] && $stable(pipe_reg[ST_E].e)), "blocked stage lost its item")

endmodule

`default_nettype wire
